// ===== src/bsr4_pkg.sv =====
// Package for the run-limited bit stuffer: shared types and fixed sizes.
// Used by the front end, the word queue and the packing back end.
package bsr4_pkg;

    // Stuffed bits of one input word: eight data bits plus at most eight zeros
    localparam int unsigned SEQ_W       = 16;
    localparam int unsigned SEQ_CNT_W   = 5;
    localparam int unsigned BYTE_W      = 8;
    // Packing register: up to seven held bits plus one full sequence
    localparam int unsigned ACC_W       = 24;
    localparam int unsigned ACC_CNT_W   = 5;
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified word as passed from the front end to the back end
    typedef struct packed {
        logic [SEQ_W-1:0]     bits;   // left aligned, earliest bit in the MSB
        logic [SEQ_CNT_W-1:0] count;  // number of valid bits (8..16)
        logic                 last;   // word closes the frame
    } t_entry;

endpackage

// ===== src/bit_stuffer_run4_top.sv =====
// Top level of the run-limited bit stuffer with byte packing.
// Depends on bsr4_pkg, bsr4_front, bsr4_fifo and bsr4_back.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one frame byte per word, with
//   i_frame_end set on the last byte of a frame. Bits go out MSB first; a
//   zero is inserted before any data bit that follows RUN_LENGTH ones.
//   Output channel (o_valid/i_ready) gives packed bytes, earliest bit in
//   the MSB; the last byte of a frame is zero padded and has o_out_last set.
//   Path: an accepted input word is written into the queue, loaded into the
//   packer and then moved, one byte at a time, to the output register.
//   The packer either loads one input word or emits one output byte, never
//   both at once, so each input word costs a load plus one emit per output
//   byte, including a frame tail. The one-byte output port and the packer
//   load step set the throughput.
//   A two-entry queue parts the front end from the packer, so input words
//   are taken while output words wait.
//   Reset (synchronous, active low) empties the queue and clears the run
//   history and held bits. When the receiver stalls, the output word holds
//   and the queue fills; o_ready then drops until space frees.
module bit_stuffer_run4_top #(
    parameter int unsigned RUN_LENGTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_frame_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);
    import bsr4_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    t_entry q_in;
    t_entry q_out;

    bsr4_front #(
        .RUN_LENGTH (RUN_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_entry   (q_in)
    );

    bsr4_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    bsr4_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_out),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule

// ===== src/bsr4_front.sv =====
// Front end of the bit stuffer: takes input words, inserts the zero bits.
// Depends on bsr4_pkg for the queue entry type.
module bsr4_front #(
    parameter int unsigned RUN_LENGTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_frame_end,
    input  logic            i_q_full,
    output logic            o_q_push,
    output bsr4_pkg::t_entry o_q_entry
);
    import bsr4_pkg::*;

    localparam logic [RUN_LENGTH-1:0] RUN_MASK = {RUN_LENGTH{1'b1}};

    logic [RUN_LENGTH-1:0] r_recent;
    logic [RUN_LENGTH-1:0] n_recent;
    logic [SEQ_W-1:0]      seq;
    logic [SEQ_CNT_W-1:0]  cnt;

    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full;

    // Walk the eight data bits, stuffing a zero after each full run of ones
    always_comb begin
        logic [RUN_LENGTH-1:0] rec;
        logic                  b;
        rec = r_recent;
        seq = '0;
        cnt = '0;
        for (int i = 7; i >= 0; i--) begin
            b = i_data_byte[i];
            if (rec == RUN_MASK) begin
                seq = {seq[SEQ_W-2:0], 1'b0};
                cnt = cnt + SEQ_CNT_W'(1);
                rec = RUN_LENGTH'({rec, 1'b0});
            end
            seq = {seq[SEQ_W-2:0], b};
            cnt = cnt + SEQ_CNT_W'(1);
            rec = RUN_LENGTH'({rec, b});
        end
        n_recent = rec;
    end

    // Left align the sequence for the packer
    always_comb begin
        o_q_entry.bits  = seq << (SEQ_CNT_W'(SEQ_W) - cnt);
        o_q_entry.count = cnt;
        o_q_entry.last  = i_frame_end;
    end

    // Run history; a frame end starts the next frame from all zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
        end else if (o_q_push) begin
            r_recent <= i_frame_end ? '0 : n_recent;
        end
    end

endmodule

// ===== src/bsr4_fifo.sv =====
// Short queue of stuffed-bit entries between front end and back end.
// Depends on bsr4_pkg for the entry type and depth.
module bsr4_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bsr4_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output bsr4_pkg::t_entry o_entry
);
    import bsr4_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_entry           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/bsr4_back.sv =====
// Back end of the bit stuffer: packs stuffed bits into output words.
// Depends on bsr4_pkg for the entry type and packing widths.
module bsr4_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  bsr4_pkg::t_entry i_q_entry,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);
    import bsr4_pkg::*;

    localparam logic [ACC_CNT_W-1:0] BYTE_CNT = ACC_CNT_W'(BYTE_W);

    logic [ACC_W-1:0]     r_acc;     // held bits, left aligned, zero below
    logic [ACC_CNT_W-1:0] r_cnt;
    logic                 r_last;    // held bits close the frame
    logic                 need_emit;
    logic                 out_free;
    logic                 emit;
    logic                 load;
    logic [ACC_W-1:0]     merged;

    // A word is due when a full byte is held or a frame tail must be flushed
    assign need_emit = (r_cnt >= BYTE_CNT) || (r_last && (r_cnt != '0));
    assign out_free  = !o_valid || i_ready;
    assign emit      = need_emit && out_free;
    assign load      = !need_emit && i_q_valid;
    assign o_q_pop   = load;

    // New sequence goes straight after the held bits
    assign merged = r_acc | ({i_q_entry.bits, {(ACC_W - SEQ_W){1'b0}}} >> r_cnt);

    // Packing register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_cnt  <= '0;
            r_last <= 1'b0;
        end else if (load) begin
            r_acc  <= merged;
            r_cnt  <= r_cnt + ACC_CNT_W'(i_q_entry.count);
            r_last <= i_q_entry.last;
        end else if (emit) begin
            if (r_cnt >= BYTE_CNT) begin
                r_acc <= r_acc << BYTE_W;
                r_cnt <= r_cnt - BYTE_CNT;
            end else begin
                r_acc <= '0;
                r_cnt <= '0;
            end
            r_last <= r_last && (r_cnt > BYTE_CNT);
        end
    end

    // Output register; tail bytes are already zero padded in the packer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_out_byte <= r_acc[ACC_W-1 -: BYTE_W];
            o_out_last <= r_last && (r_cnt <= BYTE_CNT);
        end
    end

endmodule

// ===== src/bsr4_checker.sv =====
// Port-level checks for the bit stuffer, bound to the top level.
// Depends only on the ports of bit_stuffer_run4_top.
module bsr4_checker #(
    parameter int unsigned RUN_LENGTH = 4
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_data_byte,
    input logic       i_frame_end,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);

    // Longest run of ones inside one output word
    function automatic logic [3:0] max_run(input logic [7:0] w);
        logic [3:0] cur;
        logic [3:0] best;
        cur  = '0;
        best = '0;
        for (int i = 7; i >= 0; i--) begin
            cur = w[i] ? cur + 4'd1 : 4'd0;
            if (cur > best) begin
                best = cur;
            end
        end
        return best;
    endfunction

    // After reset the queue is empty and nothing is shown
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_ready && !o_valid))
        else $error("bsr4: not idle after reset");

    // Stalled input word stays offered with its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=>
            (i_valid && $stable(i_data_byte) && $stable(i_frame_end)))
        else $error("bsr4: input word changed while stalled");

    // Stuffing never lets a run inside one output word grow beyond RUN_LENGTH ones
    a_run_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (max_run(o_out_byte) <= 4'(RUN_LENGTH)))
        else $error("bsr4: run of ones too long in output word");

    // Stalled output word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("bsr4: output word dropped while stalled");

    // Stalled output word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> ($stable(o_out_byte) && $stable(o_out_last)))
        else $error("bsr4: output payload changed while stalled");

endmodule

bind bit_stuffer_run4_top bsr4_checker #(
    .RUN_LENGTH (RUN_LENGTH)
) u_bsr4_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_data_byte (i_data_byte),
    .i_frame_end (i_frame_end),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_byte  (o_out_byte),
    .o_out_last  (o_out_last)
);
